[hw/rtl/lpwu_pkg.sv]
// Shared types, mode codes and pixel helpers for the pixel word unpacker.
`default_nettype none
package lpwu_pkg;

  localparam int WORD_W  = 32;
  localparam int PIXEL_W = 16;
  localparam int MODE_W  = 3;
  localparam int CNT_W   = 5;

  typedef logic [MODE_W-1:0] mode_t;

  localparam mode_t MODE_1BPP  = 3'd0;
  localparam mode_t MODE_2BPP  = 3'd1;
  localparam mode_t MODE_4BPP  = 3'd2;
  localparam mode_t MODE_8BPP  = 3'd3;
  localparam mode_t MODE_16BPP = 3'd4;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    mode_t             mode;
  } entry_t;

  // Pixels per word minus one.
  function automatic logic [CNT_W-1:0] last_index(input mode_t mode);
    logic [CNT_W-1:0] r;
    unique case (mode)
      MODE_1BPP:  r = 5'd31;
      MODE_2BPP:  r = 5'd15;
      MODE_4BPP:  r = 5'd7;
      MODE_8BPP:  r = 5'd3;
      default:    r = 5'd1;
    endcase
    return r;
  endfunction

  // Drop the pixel just sent from the low end of the word.
  function automatic logic [WORD_W-1:0] shift_out(input logic [WORD_W-1:0] w,
                                                  input mode_t mode);
    logic [WORD_W-1:0] r;
    unique case (mode)
      MODE_1BPP:  r = {1'b0, w[WORD_W-1:1]};
      MODE_2BPP:  r = {2'b0, w[WORD_W-1:2]};
      MODE_4BPP:  r = {4'b0, w[WORD_W-1:4]};
      MODE_8BPP:  r = {8'b0, w[WORD_W-1:8]};
      default:    r = {16'b0, w[WORD_W-1:16]};
    endcase
    return r;
  endfunction

  // Widen the low code to 8-bit gray (repeat its lowest bit) and pack as RGB565;
  // 16-bit pixels pass through.
  function automatic logic [PIXEL_W-1:0] to_rgb565(input logic [PIXEL_W-1:0] c,
                                                   input mode_t mode);
    logic [7:0]         g;
    logic [PIXEL_W-1:0] r;
    unique case (mode)
      MODE_1BPP:  g = {8{c[0]}};
      MODE_2BPP:  g = {c[1:0], {6{c[0]}}};
      MODE_4BPP:  g = {c[3:0], {4{c[0]}}};
      default:    g = c[7:0];
    endcase
    if (mode == MODE_16BPP) begin
      r = c;
    end else begin
      r = {g[7:3], g[7:2], g[7:3]};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/lpwu_front.sv]
// Front end: mode register, input acceptance and dropping of invalid modes.
`default_nettype none
module lpwu_front
  import lpwu_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [MODE_W-1:0] cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WORD_W-1:0] word,
  input  wire logic              full,
  output logic                   push,
  output entry_t                 push_data
);

  mode_t bpp_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp_mode <= MODE_1BPP;
    end else if (cfg_write) begin
      bpp_mode <= cfg_data;
    end
  end

  // Words taken in an invalid mode are accepted and dropped.
  assign in_stall       = full;
  assign push           = in_valid && !full && (bpp_mode <= MODE_16BPP);
  assign push_data.word = word;
  assign push_data.mode = bpp_mode;

endmodule
`default_nettype wire

[hw/rtl/lpwu_fifo.sv]
// Short queue of classified words between front and back ends.
`default_nettype none
module lpwu_fifo
  import lpwu_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire entry_t push_data,
  output logic        full,
  input  wire logic   pop,
  output logic        nonempty,
  output entry_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W_Q-1:0] CNT_FULL = CNT_W_Q'(DEPTH);

  entry_t              mem [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W_Q-1:0]  count;

  assign full     = (count == CNT_FULL);
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CNT_FULL)
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

[hw/rtl/lpwu_back.sv]
// Back end: serializes queued words, one RGB565 pixel per unstalled cycle.
`default_nettype none
module lpwu_back
  import lpwu_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                nonempty,
  input  wire entry_t              head,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [PIXEL_W-1:0]       pixel,
  output logic                     last
);

  logic              busy;
  logic [WORD_W-1:0] sh;
  mode_t             cur_mode;
  logic [CNT_W-1:0]  remaining;

  logic load;
  logic advance;
  logic finish;

  assign load    = !out_valid || !out_stall;
  assign advance = load && busy;
  assign finish  = advance && (remaining == '0);
  // Fetch the next word as the current one sends its last pixel: no bubble.
  assign pop     = nonempty && (!busy || finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= '0;
    end else if (pop) begin
      busy      <= 1'b1;
      remaining <= last_index(head.mode);
    end else if (advance) begin
      busy      <= !finish;
      // Hold the count at zero once the word is done.
      if (!finish) begin
        remaining <= remaining - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sh       <= head.word;
      cur_mode <= head.mode;
    end else if (advance) begin
      sh       <= shift_out(sh, cur_mode);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel <= to_rgb565(sh[PIXEL_W-1:0], cur_mode);
      last  <= (remaining == '0);
    end
  end

  a_mode_valid: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cur_mode <= MODE_16BPP))
    else $error("back end busy with an invalid mode");
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (remaining == '0))
    else $error("idle back end holds a pixel count");
  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    finish |=> (out_valid && last))
    else $error("final pixel of a word not marked");

endmodule
`default_nettype wire

[hw/rtl/lcd_pixel_word_unpacker_core.sv]
// Top level of the pixel word unpacker: front end, queue and back end.
// Each accepted 32-bit word yields 32, 16, 8, 4 or 2 RGB565 pixels (1, 2, 4, 8 or
// 16 bpp), lowest bits first, the final one marked by last; in modes 5 to 7 the
// word is accepted and dropped. The back end emits one pixel per cycle while
// out_stall is low, through a single output register; the next word waits in a
// FIFO_DEPTH-entry queue and is popped as the previous word's last pixel is
// registered. Words enter while the queue has room.
// Write bpp_mode only while the block is idle.
`default_nettype none
module lcd_pixel_word_unpacker_core
  import lpwu_pkg::*;
#(
  parameter int FIFO_DEPTH = 2
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [MODE_W-1:0]  cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [WORD_W-1:0]  word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [PIXEL_W-1:0]      pixel,
  output logic                    last
);

  logic   full;
  logic   push;
  entry_t push_data;
  logic   pop;
  logic   nonempty;
  entry_t head;

  lpwu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .word      (word),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  lpwu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .nonempty  (nonempty),
    .head      (head)
  );

  lpwu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (nonempty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel     (pixel),
    .last      (last)
  );

endmodule
`default_nettype wire
